// ===== sv/pfx_pkg.sv =====
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared constants, types and helpers of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [1:0]             status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MALFORMED = 2'd1;
  localparam status_t ST_DIV_ZERO  = 2'd2;
  localparam status_t ST_OVERFLOW  = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    value_t  lhs;
    value_t  rhs;
  } alu_req_t;

  typedef struct packed {
    logic   done;
    value_t result;
  } alu_rsp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) || (c == CHAR_SLASH);
  endfunction

  function automatic alu_op_t char_to_op(input logic [7:0] c);
    alu_op_t op;
    case (c)
      CHAR_PLUS:  op = ALU_ADD;
      CHAR_MINUS: op = ALU_SUB;
      CHAR_STAR:  op = ALU_MUL;
      default:    op = ALU_DIV;
    endcase
    return op;
  endfunction

endpackage

// ===== sv/pfx_if.sv =====
// ----------------------------------------------------------------------------
// pfx_if
// Valid/ready channels of the evaluator: character words in, result words out.
// ----------------------------------------------------------------------------
interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== sv/pfx_ram.sv =====
// ----------------------------------------------------------------------------
// pfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfx_alu.sv =====
// ----------------------------------------------------------------------------
// pfx_alu
// Iterative arithmetic unit: one shared adder serves add, subtract,
// shift-add multiply and restoring signed division.
// ----------------------------------------------------------------------------
module pfx_alu
  import pfx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int VW = VALUE_WIDTH;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  alu_op_t           op_r, op_nxt;
  value_t            acc_r, acc_nxt;   // sum, product or remainder
  value_t            opb_r, opb_nxt;   // addend, multiplicand or divisor
  value_t            q_r, q_nxt;       // multiplier or dividend/quotient
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  value_t            res_r, res_nxt;

  logic [VW+1:0] opa_x, opb_x, sum_x;
  logic          sub;
  logic          div_ok;
  value_t        div_rem, div_quo;
  value_t        mag_l, mag_r;

  // Shared adder
  always_comb begin
    opa_x = {2'b00, acc_r};
    opb_x = {2'b00, opb_r};
    sub   = 1'b0;
    case (op_r)
      ALU_ADD: sub = 1'b0;
      ALU_SUB: sub = 1'b1;
      ALU_MUL: opb_x = q_r[0] ? {2'b00, opb_r} : '0;
      ALU_DIV: begin
        opa_x = {1'b0, acc_r, q_r[VW-1]};
        sub   = 1'b1;
      end
      default: sub = 1'b0;
    endcase
    sum_x   = opa_x + (opb_x ^ {(VW+2){sub}}) + (VW+2)'(sub);
    div_ok  = ~sum_x[VW+1];
    div_rem = div_ok ? sum_x[VW-1:0] : {acc_r[VW-2:0], q_r[VW-1]};
    div_quo = {q_r[VW-2:0], div_ok};
  end

  always_comb begin
    mag_l = req.lhs[VW-1] ? (value_t'(0) - req.lhs) : req.lhs;
    mag_r = req.rhs[VW-1] ? (value_t'(0) - req.rhs) : req.rhs;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    opb_nxt  = opb_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      neg_nxt  = req.lhs[VW-1] ^ req.rhs[VW-1];
      case (req.op) inside
        ALU_ADD, ALU_SUB: begin
          acc_nxt = req.lhs;
          opb_nxt = req.rhs;
          cnt_nxt = '0;
        end
        ALU_MUL: begin
          acc_nxt = '0;
          opb_nxt = req.lhs;
          q_nxt   = req.rhs;
          cnt_nxt = STEP_W'(VW - 1);
        end
        default: begin
          acc_nxt = '0;
          opb_nxt = mag_r;
          q_nxt   = mag_l;
          cnt_nxt = STEP_W'(VW - 1);
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      case (op_r)
        ALU_MUL: begin
          acc_nxt = sum_x[VW-1:0];
          opb_nxt = opb_r << 1;
          q_nxt   = q_r >> 1;
        end
        ALU_DIV: begin
          acc_nxt = div_rem;
          q_nxt   = div_quo;
        end
        default: acc_nxt = sum_x[VW-1:0];
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == ALU_DIV) begin
          res_nxt = neg_r ? (value_t'(0) - div_quo) : div_quo;
        end else begin
          res_nxt = sum_x[VW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    opb_r <= opb_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== sv/postfix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix (RPN) evaluator: one character word per handshake, value stack in RAM.
// ----------------------------------------------------------------------------
// Steps: a digit or an ignored word is taken in S_IDLE; other non-operators pass S_FLUSH,
//   operators also S_OP, S_RHS, S_LHS and S_EXEC, which waits on the bit-per-cycle ALU loop.
// The word marked last then goes on through S_END, S_READ0 and S_EMIT to the result,
//   plus any wait for the output register; an error ends an operator early.
// Throughput: one character at a time; the input is not ready while busy.
// Reset: synchronous, active low; clears the stack count, operand, error status and output valid.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core
  import pfx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pfx_in_if.sink       in_ch,
  pfx_out_if.source    out_ch
);

  // One-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,  // wait for a character word
    S_FLUSH = 9'b000000010,  // push the pending operand
    S_OP    = 9'b000000100,  // check depth, read right operand
    S_RHS   = 9'b000001000,  // capture right operand, read left
    S_LHS   = 9'b000010000,  // check divisor, start ALU
    S_EXEC  = 9'b000100000,  // wait for ALU, push result
    S_END   = 9'b001000000,  // finish the character; judge at end of expression
    S_READ0 = 9'b010000000,  // read the stack bottom
    S_EMIT  = 9'b100000000   // load the result word
  } state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        last_r, last_nxt;
  count_t      count_r, count_nxt;
  value_t      accum_r, accum_nxt;
  logic        pending_r, pending_nxt;
  status_t     err_r, err_nxt;
  status_t     status_r, status_nxt;
  value_t      rhs_r, rhs_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  status_t     out_status_r, out_status_nxt;

  // Stack RAM
  logic   ram_we;
  ptr_t   ram_waddr;
  value_t ram_wdata;
  ptr_t   ram_raddr;
  value_t ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic       in_acc;
  logic       flush_ovf;
  logic       flush_wr;
  logic [7:0] digit;
  status_t    fin_err;
  count_t     fin_count;

  pfx_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfx_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign digit       = in_ch.char_code - CHAR_ZERO;

  // A pending operand either lands on the stack or overflows it
  assign flush_ovf = pending_r && (count_r >= count_t'(STACK_DEPTH));
  assign flush_wr  = pending_r && !flush_ovf;

  always_comb begin
    state_nxt      = state_r;
    char_nxt       = char_r;
    last_nxt       = last_r;
    count_nxt      = count_r;
    accum_nxt      = accum_r;
    pending_nxt    = pending_r;
    err_nxt        = err_r;
    status_nxt     = status_r;
    rhs_nxt        = rhs_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    fin_err        = err_r;
    fin_count      = count_r;

    ram_we    = 1'b0;
    ram_waddr = count_r[PTR_W-1:0];
    ram_wdata = accum_r;
    ram_raddr = '0;

    alu_req.start = 1'b0;
    alu_req.op    = char_to_op(char_r);
    alu_req.lhs   = ram_rdata;
    alu_req.rhs   = rhs_r;

    // Drop the result word once the sink takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          char_nxt = in_ch.char_code;
          last_nxt = in_ch.end_of_expr;
          if (err_r != ST_OK) begin
            // Sticky error: ignore the word, only the end matters
            state_nxt = in_ch.end_of_expr ? S_END : S_IDLE;
          end else if (is_digit(in_ch.char_code)) begin
            accum_nxt   = (accum_r << 3) + (accum_r << 1) + value_t'(digit);
            pending_nxt = 1'b1;
            state_nxt   = in_ch.end_of_expr ? S_END : S_IDLE;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        ram_we      = flush_wr;
        pending_nxt = 1'b0;
        accum_nxt   = '0;
        if (flush_wr) begin
          count_nxt = count_r + 1'b1;
        end
        if (flush_ovf) begin
          err_nxt   = ST_OVERFLOW;
          state_nxt = S_END;
        end else if (is_operator(char_r)) begin
          state_nxt = S_OP;
        end else begin
          state_nxt = S_END;
        end
      end

      S_OP: begin
        if (count_r < count_t'(2)) begin
          err_nxt   = ST_MALFORMED;
          state_nxt = S_END;
        end else begin
          ram_raddr = ptr_t'(count_r - 1'b1);
          state_nxt = S_RHS;
        end
      end

      S_RHS: begin
        rhs_nxt   = ram_rdata;
        ram_raddr = ptr_t'(count_r - count_t'(2));
        state_nxt = S_LHS;
      end

      S_LHS: begin
        if ((alu_req.op == ALU_DIV) && (rhs_r == '0)) begin
          err_nxt   = ST_DIV_ZERO;
          state_nxt = S_END;
        end else begin
          // Pop both operands; the left one comes straight from the RAM
          alu_req.start = 1'b1;
          count_nxt     = count_r - count_t'(2);
          state_nxt     = S_EXEC;
        end
      end

      S_EXEC: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = alu_rsp.result;
          count_nxt = count_r + 1'b1;
          state_nxt = S_END;
        end
      end

      S_END: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else begin
          // Push a trailing operand, then judge the final depth
          if (err_r == ST_OK) begin
            ram_we      = flush_wr;
            pending_nxt = 1'b0;
            accum_nxt   = '0;
            if (flush_ovf) begin
              fin_err = ST_OVERFLOW;
            end
            if (flush_wr) begin
              fin_count = count_r + 1'b1;
            end
          end
          count_nxt = fin_count;
          err_nxt   = fin_err;
          if (fin_err != ST_OK) begin
            status_nxt = fin_err;
          end else if (fin_count != count_t'(1)) begin
            status_nxt = ST_MALFORMED;
          end else begin
            status_nxt = ST_OK;
          end
          state_nxt = S_READ0;
        end
      end

      S_READ0: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // Hold until the output register is free, then clear for the next expression
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = (status_r == ST_OK) ? 32'(ram_rdata) : 32'd0;
          out_status_nxt = status_r;
          count_nxt      = '0;
          accum_nxt      = '0;
          pending_nxt    = 1'b0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      accum_r     <= '0;
      pending_r   <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      accum_r     <= accum_nxt;
      pending_r   <= pending_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    char_r       <= char_nxt;
    last_r       <= last_nxt;
    status_r     <= status_nxt;
    rhs_r        <= rhs_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = $signed(out_value_r);
  assign out_ch.status = out_status_r;

endmodule

// ===== sv/pfx_checker.sv =====
// ----------------------------------------------------------------------------
// pfx_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfx_checker
  import pfx_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_status
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result word changed while stalled");

  // The last word of an expression always takes the block busy
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end |=> !in_ready)
    else $error("input ready straight after the last word");

  // A failed expression carries a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_value == 32'd0))
    else $error("non-zero value with error status");

  // A word that is not last never releases a result right after it
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_end |=> !$rose(out_valid))
    else $error("result after a word not marked last");

  // Block is back to idle when a new result shows
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while still busy");

endmodule

bind postfix_expression_evaluator_core pfx_checker u_pfx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_end     (in_ch.end_of_expr),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);
